[sv/yiqcd_pkg.sv]
// Shared types and constants for the YIQ pixel color delta block.
// No dependencies; used by yiqcd_blend and yiq_pixel_color_delta.
`default_nettype none

package yiqcd_pkg;

   typedef logic [7:0] chan_type;

   // Per-stage load enables handed to the alpha blend pipeline
   typedef struct packed {
      logic s0;
      logic s1;
      logic s2;
   } blend_en_type;

   localparam int N_STAGES    = 11;
   localparam int DELTA_W     = 25;
   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 32;
   localparam int CSH         = 16;

   // YIQ conversion, round(coef * 2^16); rows Y, I, Q; columns R, G, B.
   // Signs are applied in the adder stage.
   localparam logic [15:0] KYIQ [0:2][0:2] = '{
      '{16'd19588, 16'd38445, 16'd7503},
      '{16'd39058, 16'd17968, 16'd21090},
      '{16'd13859, 16'd34250, 16'd20391}
   };

   // Distance weights for dY^2, dI^2, dQ^2
   localparam logic [15:0] WGT [0:2] = '{16'd33115, 16'd19595, 16'd12825};

   localparam logic [63:0] DIST_MAX = 64'hFF_FFFF;

endpackage

`default_nettype wire

[sv/yiqcd_blend.sv]
// Three-stage pipeline that blends one 8-bit channel onto white by its alpha.
// Depends on yiqcd_pkg; instantiated by yiq_pixel_color_delta.
`default_nettype none

module yiqcd_blend
   import yiqcd_pkg::*;
#(
   parameter int FRAC_BITS = 8
) (
   input  logic                   clock,
   input  blend_en_type           en,
   input  chan_type               chan,
   input  chan_type               alpha,
   output logic [FRAC_BITS+7:0]   blended
);

   localparam int YW = FRAC_BITS + 9;
   localparam int K  = FRAC_BITS + 17;
   localparam int RW = FRAC_BITS + 10;
   localparam int PW = YW + RW;
   localparam logic [RW-1:0] RECIP = RW'(((64'd1 << K) + 64'd254) / 64'd255);

   logic [15:0]          mix_ff, mix_in;
   logic [7:0]           quo_ff, quo_in, quo2_ff;
   logic [YW-1:0]        rem_ff, rem_in;
   logic [FRAC_BITS-1:0] frac_ff, frac_in;
   logic [8:0]           fold;
   logic [7:0]           rem8;
   logic [PW-1:0]        rprod;

   // x = c*a + 255*(255-a)
   assign mix_in = 16'(chan) * 16'(alpha) + 16'(8'd255 - alpha) * 16'd255;

   // x / 255 via 2^8 = 1 (mod 255): hi + lo needs at most one correction
   always_comb begin
      fold = 9'(mix_ff[15:8]) + 9'(mix_ff[7:0]);
      if (fold >= 9'd255) begin
         quo_in = mix_ff[15:8] + 8'd1;
         rem8   = 8'(fold - 9'd255);
      end else begin
         quo_in = mix_ff[15:8];
         rem8   = fold[7:0];
      end
      rem_in = (YW'(rem8) << FRAC_BITS) + YW'(127);
   end

   // fraction = (r*2^F + 127) / 255 by reciprocal, exact over this range
   assign rprod   = PW'(rem_ff) * PW'(RECIP);
   assign frac_in = rprod[K+FRAC_BITS-1:K];

   always_ff @(posedge clock) begin
      if (en.s0) begin
         mix_ff <= mix_in;
      end
      if (en.s1) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
      if (en.s2) begin
         quo2_ff <= quo_ff;
         frac_ff <= frac_in;
      end
   end

   assign blended = {quo2_ff, frac_ff};

endmodule

`default_nettype wire

[sv/yiq_pixel_color_delta.sv]
// Top level: YIQ color delta of two RGBA8 pixels, fully pipelined.
// Depends on yiqcd_pkg and yiqcd_blend.
`default_nettype none

// Channel   Dir  tdata                                         tuser
// req_      in   [63:0] r1,g1,b1,a1,r2,g2,b2,a2 (8b each)      y_only
// rsp_      out  [24:0] delta (signed, FRAC_BITS frac), zeros  identical
//
// One transaction per clock sustained while rsp_tready is high; the result
// reaches rsp_tvalid through the 11 register stages of the datapath
// (blend 3, difference 1, YIQ multiply and round 2, square and weight 4,
// output 1). Valid bits travel with the data; a stage loads when it is empty
// or the stage after it moves, so bubbles close up under rsp_tready stalls.
// Reset clears only the valid bits; no clearing pass.

module yiq_pixel_color_delta
   import yiqcd_pkg::*;
#(
   parameter int FRAC_BITS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // r1, g1, b1, a1, r2, g2, b2, a2
   input  logic                   req_tuser,   // y_only
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // delta[24:0], zero fill
   output logic                   rsp_tuser    // identical
);

   localparam int BW    = FRAC_BITS + 8;        // blended channel
   localparam int DW    = FRAC_BITS + 9;        // signed differences, dY
   localparam int QW    = FRAC_BITS + 10;       // dY/dI/dQ, I and Q rows run past DW
   localparam int PW    = FRAC_BITS + 26;       // coef * difference
   localparam int MW    = FRAC_BITS + 9;        // magnitude
   localparam int SQW   = 2 * MW;               // square
   localparam int LO    = SQW / 2;              // split point for weighting
   localparam int HIW   = SQW - LO;
   localparam int WPW   = HIW + 16;             // weight * half square
   localparam int TW    = SQW + 16;             // full weighted term
   localparam int AW    = TW + 2;               // sum of three terms
   localparam int ACCW  = AW - (FRAC_BITS + 16);
   localparam logic [PW-1:0] YIQ_HALF  = PW'(1) << (CSH - 1);
   localparam logic [AW-1:0] DIST_HALF = AW'(1) << (FRAC_BITS + CSH - 1);

   // ------------------------------------------------------------------
   // Stage handshake
   // ------------------------------------------------------------------
   logic [N_STAGES-1:0] valid_ff, valid_in, adv;
   logic [N_STAGES-1:0] ident_ff, ident_in, yonly_ff, yonly_in;
   logic                ident_cmp;

   assign adv[N_STAGES-1] = !valid_ff[N_STAGES-1] || rsp_tready;
   for (genvar i = 0; i < N_STAGES - 1; i++) begin : g_adv
      assign adv[i] = !valid_ff[i] || adv[i+1];
   end

   assign req_tready = adv[0];
   assign ident_cmp  = req_tdata[31:0] == req_tdata[63:32];
   assign valid_in   = {valid_ff[N_STAGES-2:0], req_tvalid};
   assign ident_in   = {ident_ff[N_STAGES-2:0], ident_cmp};
   assign yonly_in   = {yonly_ff[N_STAGES-2:0], req_tuser};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < N_STAGES; i++) begin
            if (adv[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < N_STAGES; i++) begin
         if (adv[i]) begin
            ident_ff[i] <= ident_in[i];
            yonly_ff[i] <= yonly_in[i];
         end
      end
   end

   // ------------------------------------------------------------------
   // Stages 0-2: blend each channel onto white
   // ------------------------------------------------------------------
   blend_en_type     blend_en;
   logic [BW-1:0]    blend1 [0:2];
   logic [BW-1:0]    blend2 [0:2];

   assign blend_en = '{s0: adv[0], s1: adv[1], s2: adv[2]};

   for (genvar c = 0; c < 3; c++) begin : g_blend
      yiqcd_blend #(.FRAC_BITS(FRAC_BITS)) u_blend1 (
         .clock   (clock),
         .en      (blend_en),
         .chan    (req_tdata[8*c +: 8]),
         .alpha   (req_tdata[31:24]),
         .blended (blend1[c])
      );
      yiqcd_blend #(.FRAC_BITS(FRAC_BITS)) u_blend2 (
         .clock   (clock),
         .en      (blend_en),
         .chan    (req_tdata[32 + 8*c +: 8]),
         .alpha   (req_tdata[63:56]),
         .blended (blend2[c])
      );
   end

   // ------------------------------------------------------------------
   // Stage 3: channel differences; stage 4: YIQ products
   // Stage 5: signed sums, rounded half away from zero
   // ------------------------------------------------------------------
   logic signed [DW-1:0] diff_ff [0:2];
   logic signed [PW-1:0] prod_ff [0:2][0:2];
   logic signed [QW-1:0] yiq_ff  [0:2];
   logic signed [PW-1:0] yiq_sum [0:2];
   logic signed [PW-1:0] yiq_rnd [0:2];

   always_comb begin
      yiq_sum[0] = prod_ff[0][0] + prod_ff[0][1] + prod_ff[0][2];
      yiq_sum[1] = prod_ff[1][0] - prod_ff[1][1] - prod_ff[1][2];
      yiq_sum[2] = prod_ff[2][0] - prod_ff[2][1] + prod_ff[2][2];
      for (int k = 0; k < 3; k++) begin
         if (yiq_sum[k][PW-1]) begin
            yiq_rnd[k] = (yiq_sum[k] + $signed(YIQ_HALF) - PW'(1)) >>> CSH;
         end else begin
            yiq_rnd[k] = (yiq_sum[k] + $signed(YIQ_HALF)) >>> CSH;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         if (adv[3]) begin
            diff_ff[c] <= $signed({1'b0, blend1[c]}) - $signed({1'b0, blend2[c]});
         end
      end
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if (adv[4]) begin
               prod_ff[r][c] <= PW'(diff_ff[c]) * PW'($signed({1'b0, KYIQ[r][c]}));
            end
         end
      end
      for (int k = 0; k < 3; k++) begin
         if (adv[5]) begin
            yiq_ff[k] <= yiq_rnd[k][QW-1:0];
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 6: squares; stage 7: weights on split squares
   // Stage 8: rejoin; stage 9: sum and round; dY rides alongside
   // ------------------------------------------------------------------
   logic [MW-1:0]        mag     [0:2];
   logic [QW-1:0]        neg     [0:2];
   logic [SQW-1:0]       sq_ff   [0:2];
   logic [WPW-1:0]       wlo_ff  [0:2];
   logic [WPW-1:0]       whi_ff  [0:2];
   logic [TW-1:0]        term_ff [0:2];
   logic [AW-1:0]        dist_sum;
   logic [ACCW-1:0]      acc_ff;
   logic signed [DW-1:0] dy_ff   [6:9];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         neg[k] = QW'(-yiq_ff[k]);
         mag[k] = yiq_ff[k][QW-1] ? neg[k][MW-1:0] : yiq_ff[k][MW-1:0];
      end
      dist_sum = AW'(term_ff[0]) + AW'(term_ff[1]) + AW'(term_ff[2]) + DIST_HALF;
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         if (adv[6]) begin
            sq_ff[k] <= SQW'(mag[k]) * SQW'(mag[k]);
         end
         if (adv[7]) begin
            wlo_ff[k] <= WPW'(WGT[k]) * WPW'(sq_ff[k][LO-1:0]);
            whi_ff[k] <= WPW'(WGT[k]) * WPW'(sq_ff[k][SQW-1:LO]);
         end
         if (adv[8]) begin
            term_ff[k] <= (TW'(whi_ff[k]) << LO) + TW'(wlo_ff[k]);
         end
      end
      if (adv[9]) begin
         acc_ff <= dist_sum[AW-1:FRAC_BITS+16];
      end
      if (adv[6]) begin
         dy_ff[6] <= yiq_ff[0][DW-1:0];
      end
      for (int s = 7; s <= 9; s++) begin
         if (adv[s]) begin
            dy_ff[s] <= dy_ff[s-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 10: saturate, select mode, output register
   // ------------------------------------------------------------------
   logic [DELTA_W-1:0] delta_ff, delta_in, dist_val;

   always_comb begin
      dist_val = (64'(acc_ff) > DIST_MAX) ? DELTA_W'(DIST_MAX) : DELTA_W'(acc_ff);
      if (ident_ff[9]) begin
         delta_in = '0;
      end else if (yonly_ff[9]) begin
         delta_in = DELTA_W'(dy_ff[9]);
      end else begin
         delta_in = dist_val;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[10]) begin
         delta_ff <= delta_in;
      end
   end

   assign rsp_tvalid = valid_ff[N_STAGES-1];
   assign rsp_tdata  = RSP_TDATA_W'(delta_ff);
   assign rsp_tuser  = ident_ff[N_STAGES-1];

endmodule

`default_nettype wire
